>>> hw/rtl/fas_pkg.sv
package fas_pkg;

	// configuration register indexes
	localparam logic CFG_GAIN   = 1'b0;
	localparam logic CFG_RADIUS = 1'b1;

	// reset values of the configuration registers (Q16.16)
	localparam logic [30:0] GAIN_RST   = 31'd65536;
	localparam logic [30:0] RADIUS_RST = 31'd655360;

	// low slice of the velocity sum magnitude fed to the multiplier
	localparam int LO_W = 24;
	// Q16.16 fraction bits
	localparam int FRAC_W = 16;
	// heading in Q2.14: one half LSB for rounding
	localparam int HD_W = 15;
	localparam logic [45:0] CLAMP_RND = 46'd8192;
	// magnitudes are normalised below this bit before squaring
	localparam int NORM_BIT = 30;
	// first probe bit of the integer square root
	localparam logic [61:0] SQRT_TOP = 62'h1000_0000_0000_0000;

	typedef enum logic [4:0] {
		OP_NONE,
		OP_LOAD,
		OP_SQUARE,
		OP_ACCUM,
		OP_MUL_LO,
		OP_MUL_HI,
		OP_DIV_LOAD_W,
		OP_DIV_STEP,
		OP_MG_STORE,
		OP_PREP,
		OP_ZERO_OUT,
		OP_SHIFT,
		OP_CSQ,
		OP_CADD,
		OP_SQRT_INIT,
		OP_SQRT_STEP,
		OP_DIV_LOAD_H,
		OP_HD_STORE,
		OP_MAXSQ,
		OP_E_INIT,
		OP_E_SQ,
		OP_E_ADD,
		OP_OVER,
		OP_CLAMP_MUL,
		OP_WRITE_OUT
	} op_t;

	typedef struct packed {
		op_t        op;
		logic [1:0] axis;
	} cmd_t;

	typedef struct packed {
		logic last;
		logic big_zero;
		logic need_shift;
	} sts_t;

endpackage

>>> hw/rtl/fas_if.sv
// neighbour entry channel
interface fas_nbr_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] self_pos_x;
	logic signed [31:0] self_pos_y;
	logic signed [31:0] self_pos_z;
	logic signed [31:0] other_pos_x;
	logic signed [31:0] other_pos_y;
	logic signed [31:0] other_pos_z;
	logic signed [31:0] other_vel_x;
	logic signed [31:0] other_vel_y;
	logic signed [31:0] other_vel_z;
	logic               is_self;
	logic               last_neighbor;
	logic        [30:0] max_speed;

	modport source (output valid, self_pos_x, self_pos_y, self_pos_z, other_pos_x,
		other_pos_y, other_pos_z, other_vel_x, other_vel_y, other_vel_z, is_self,
		last_neighbor, max_speed, input ready);
	modport sink (input valid, self_pos_x, self_pos_y, self_pos_z, other_pos_x,
		other_pos_y, other_pos_z, other_vel_x, other_vel_y, other_vel_z, is_self,
		last_neighbor, max_speed, output ready);
endinterface

// steering result channel
interface fas_res_if;
	logic               valid;
	logic               ready;
	logic signed [31:0] desired_vel_x;
	logic signed [31:0] desired_vel_y;
	logic signed [31:0] desired_vel_z;
	logic signed [15:0] heading_x;
	logic signed [15:0] heading_y;
	logic signed [15:0] heading_z;

	modport source (output valid, desired_vel_x, desired_vel_y, desired_vel_z,
		heading_x, heading_y, heading_z, input ready);
	modport sink (input valid, desired_vel_x, desired_vel_y, desired_vel_z,
		heading_x, heading_y, heading_z, output ready);
endinterface

// configuration write channel
interface fas_cfg_if;
	logic        valid;
	logic        ready;
	logic        index;
	logic [31:0] data;

	modport source (output valid, index, data, input ready);
	modport sink (input valid, index, data, output ready);
endinterface

>>> hw/rtl/fas_ctrl.sv
module fas_ctrl #(
	parameter int MAX_NEIGHBORS = 256
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	output logic          out_valid,
	input  logic          out_ready,
	input  fas_pkg::sts_t sts,
	output fas_pkg::cmd_t cmd
);

	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
	localparam int DW    = 32 + CNT_W + 15;
	localparam int IT_W  = $clog2(DW);

	typedef enum logic [4:0] {
		ST_IDLE, ST_SQ, ST_ACC, ST_MLO, ST_MHI, ST_DLW, ST_DIV, ST_MGS, ST_PREP,
		ST_ZOUT, ST_SHF, ST_CSQ, ST_CADD, ST_SQI, ST_SQS, ST_DLH, ST_HST, ST_MSQ,
		ST_EIN, ST_ESQ, ST_EADD, ST_OVR, ST_CLM, ST_WOUT, ST_OUT
	} state_t;

	state_t          state_q;
	logic [1:0]      axis_q;
	logic [IT_W-1:0] it_q;
	logic            phase_q;

	assign in_ready  = (state_q == ST_IDLE);
	assign out_valid = (state_q == ST_OUT);

	// command decode
	always_comb begin
		cmd.axis = axis_q;
		unique case (state_q)
			ST_IDLE: cmd.op = in_valid ? fas_pkg::OP_LOAD : fas_pkg::OP_NONE;
			ST_SQ:   cmd.op = fas_pkg::OP_SQUARE;
			ST_ACC:  cmd.op = fas_pkg::OP_ACCUM;
			ST_MLO:  cmd.op = fas_pkg::OP_MUL_LO;
			ST_MHI:  cmd.op = fas_pkg::OP_MUL_HI;
			ST_DLW:  cmd.op = fas_pkg::OP_DIV_LOAD_W;
			ST_DIV:  cmd.op = fas_pkg::OP_DIV_STEP;
			ST_MGS:  cmd.op = fas_pkg::OP_MG_STORE;
			ST_PREP: cmd.op = fas_pkg::OP_PREP;
			ST_ZOUT: cmd.op = fas_pkg::OP_ZERO_OUT;
			ST_SHF:  cmd.op = sts.need_shift ? fas_pkg::OP_SHIFT : fas_pkg::OP_NONE;
			ST_CSQ:  cmd.op = fas_pkg::OP_CSQ;
			ST_CADD: cmd.op = fas_pkg::OP_CADD;
			ST_SQI:  cmd.op = fas_pkg::OP_SQRT_INIT;
			ST_SQS:  cmd.op = fas_pkg::OP_SQRT_STEP;
			ST_DLH:  cmd.op = fas_pkg::OP_DIV_LOAD_H;
			ST_HST:  cmd.op = fas_pkg::OP_HD_STORE;
			ST_MSQ:  cmd.op = fas_pkg::OP_MAXSQ;
			ST_EIN:  cmd.op = fas_pkg::OP_E_INIT;
			ST_ESQ:  cmd.op = fas_pkg::OP_E_SQ;
			ST_EADD: cmd.op = fas_pkg::OP_E_ADD;
			ST_OVR:  cmd.op = fas_pkg::OP_OVER;
			ST_CLM:  cmd.op = fas_pkg::OP_CLAMP_MUL;
			ST_WOUT: cmd.op = fas_pkg::OP_WRITE_OUT;
			ST_OUT:  cmd.op = fas_pkg::OP_NONE;
			default: cmd.op = fas_pkg::OP_NONE;
		endcase
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			axis_q  <= 2'd0;
			it_q    <= '0;
			phase_q <= 1'b0;
		end else begin
			unique case (state_q)
				ST_IDLE: if (in_valid) state_q <= ST_SQ;
				ST_SQ:   state_q <= ST_ACC;
				ST_ACC: begin
					axis_q  <= 2'd0;
					state_q <= sts.last ? ST_MLO : ST_IDLE;
				end
				ST_MLO:  state_q <= ST_MHI;
				ST_MHI:  state_q <= ST_DLW;
				ST_DLW: begin
					it_q    <= IT_W'(DW - 1);
					phase_q <= 1'b0;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					if (it_q == '0) state_q <= phase_q ? ST_HST : ST_MGS;
					else it_q <= it_q - 1'b1;
				end
				ST_MGS: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= ST_PREP;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_MLO;
					end
				end
				ST_PREP: state_q <= sts.big_zero ? ST_ZOUT : ST_SHF;
				ST_ZOUT: state_q <= ST_OUT;
				ST_SHF: begin
					if (!sts.need_shift) begin
						axis_q  <= 2'd0;
						state_q <= ST_CSQ;
					end
				end
				ST_CSQ:  state_q <= ST_CADD;
				ST_CADD: begin
					if (axis_q == 2'd2) state_q <= ST_SQI;
					else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_CSQ;
					end
				end
				ST_SQI: begin
					it_q    <= IT_W'(30);
					state_q <= ST_SQS;
				end
				ST_SQS: begin
					if (it_q == '0) begin
						axis_q  <= 2'd0;
						state_q <= ST_DLH;
					end else it_q <= it_q - 1'b1;
				end
				ST_DLH: begin
					it_q    <= IT_W'(DW - 1);
					phase_q <= 1'b1;
					state_q <= ST_DIV;
				end
				ST_HST: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= ST_MSQ;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_DLH;
					end
				end
				ST_MSQ:  state_q <= ST_EIN;
				ST_EIN:  state_q <= ST_ESQ;
				ST_ESQ:  state_q <= ST_EADD;
				ST_EADD: begin
					if (axis_q == 2'd2) begin
						axis_q  <= 2'd0;
						state_q <= ST_OVR;
					end else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_ESQ;
					end
				end
				ST_OVR:  state_q <= ST_CLM;
				ST_CLM:  state_q <= ST_WOUT;
				ST_WOUT: begin
					if (axis_q == 2'd2) state_q <= ST_OUT;
					else begin
						axis_q  <= axis_q + 1'b1;
						state_q <= ST_CLM;
					end
				end
				ST_OUT:  if (out_ready) state_q <= ST_IDLE;
				default: state_q <= ST_IDLE;
			endcase
		end
	end

endmodule

>>> hw/rtl/fas_dp.sv
module fas_dp #(
	parameter int MAX_NEIGHBORS = 256
) (
	input  logic               clk,
	input  logic               arst_n,
	input  fas_pkg::cmd_t      cmd,
	output fas_pkg::sts_t      sts,
	// configuration writes
	input  logic               cfg_we,
	input  logic               cfg_index,
	input  logic [31:0]        cfg_data,
	// neighbour entry
	input  logic signed [31:0] self_pos [0:2],
	input  logic signed [31:0] other_pos [0:2],
	input  logic signed [31:0] other_vel [0:2],
	input  logic               is_self,
	input  logic               last_neighbor,
	input  logic [30:0]        max_speed,
	// result
	output logic signed [31:0] desired [0:2],
	output logic signed [15:0] heading [0:2]
);

	localparam int CNT_W = $clog2(MAX_NEIGHBORS + 1);
	localparam int SUM_W = 32 + CNT_W;
	localparam int HI_W  = SUM_W - fas_pkg::LO_W;
	localparam int PW    = SUM_W + 31;
	localparam int DW    = PW - fas_pkg::FRAC_W;
	localparam int PLO_W = fas_pkg::LO_W + 31;

	// configuration and accumulators
	logic [30:0]              gain_q, radius_q;
	logic signed [SUM_W-1:0]  sum_q [0:2];
	logic [CNT_W-1:0]         cnt_q;

	// captured entry
	logic [30:0]              ad_q [0:2];
	logic                     far_q, self_q, last_q;
	logic signed [31:0]       vel_q [0:2];
	logic [30:0]              maxs_q;

	// distance squares
	logic [61:0]              sqd_s1 [0:2];
	logic [61:0]              r2_s1;

	// shared multiplier
	logic [31:0]              mul_a, mul_b;
	logic [63:0]              mul_s1;

	// final computation
	logic [PLO_W-1:0]         plo_q;
	logic [DW-1:0]            dvd_q;
	logic [30:0]              dvs_q, rem_q;
	logic [DW-1:0]            mg_q [0:2];
	logic [2:0]               sg_q;
	logic [DW-1:0]            cs_q [0:2];
	logic [61:0]              sqsum_q, sv_q, sr_q, sb_q;
	logic [fas_pkg::HD_W-1:0] hd_q [0:2];
	logic [61:0]              msq_q;
	logic [63:0]              e_q;
	logic                     over_q;
	logic signed [31:0]       des_q [0:2];
	logic signed [15:0]       head_q [0:2];

	// combinational helpers
	logic [32:0]              diff [0:2];
	logic [32:0]              adiff [0:2];
	logic [63:0]              d2;
	logic                     hit;
	logic [SUM_W-1:0]         smag;
	logic [PW-1:0]            p_full;
	logic [31:0]              dtry, ddif;
	logic                     dge;
	logic [61:0]              sprobe;
	logic [45:0]              rnd;
	logic [31:0]              vmag;
	logic [15:0]              hmag;

	assign sts.last       = last_q;
	assign sts.big_zero   = (mg_q[0] == '0) && (mg_q[1] == '0) && (mg_q[2] == '0);
	assign sts.need_shift = (cs_q[0][DW-1:fas_pkg::NORM_BIT] != '0) ||
		(cs_q[1][DW-1:fas_pkg::NORM_BIT] != '0) ||
		(cs_q[2][DW-1:fas_pkg::NORM_BIT] != '0);

	assign desired = des_q;
	assign heading = head_q;

	// per-axis distance on the incoming entry
	always_comb begin
		for (int i = 0; i < 3; i++) begin
			diff[i]  = {self_pos[i][31], self_pos[i]} - {other_pos[i][31], other_pos[i]};
			adiff[i] = diff[i][32] ? (33'd0 - diff[i]) : diff[i];
		end
	end

	// in-range test on the squared distance
	assign d2  = 64'(sqd_s1[0]) + 64'(sqd_s1[1]) + 64'(sqd_s1[2]);
	assign hit = !self_q && !far_q && (d2 <= 64'(r2_s1)) &&
		(cnt_q < CNT_W'(MAX_NEIGHBORS));

	assign smag   = sum_q[cmd.axis][SUM_W-1] ? (SUM_W'(0) - sum_q[cmd.axis])
		: sum_q[cmd.axis];
	assign p_full = {mul_s1[HI_W+30:0], {fas_pkg::LO_W{1'b0}}} + PW'(plo_q);

	// restoring divider step
	assign dtry = {rem_q, dvd_q[DW-1]};
	assign dge  = dtry >= {1'b0, dvs_q};
	assign ddif = dtry - {1'b0, dvs_q};

	assign sprobe = sr_q + sb_q;

	// clamp rounding and output sign
	assign rnd  = mul_s1[45:0] + fas_pkg::CLAMP_RND;
	assign vmag = over_q ? rnd[45:14] : mg_q[cmd.axis][31:0];
	assign hmag = {1'b0, hd_q[cmd.axis]};

	// multiplier operand select
	always_comb begin
		mul_a = '0;
		mul_b = '0;
		case (cmd.op)
			fas_pkg::OP_MUL_LO: begin
				mul_a = {{(32 - fas_pkg::LO_W){1'b0}}, smag[fas_pkg::LO_W-1:0]};
				mul_b = {1'b0, gain_q};
			end
			fas_pkg::OP_MUL_HI: begin
				mul_a = {{(32 - HI_W){1'b0}}, smag[SUM_W-1:fas_pkg::LO_W]};
				mul_b = {1'b0, gain_q};
			end
			fas_pkg::OP_CSQ: begin
				mul_a = {2'b0, cs_q[cmd.axis][29:0]};
				mul_b = {2'b0, cs_q[cmd.axis][29:0]};
			end
			fas_pkg::OP_MAXSQ: begin
				mul_a = {1'b0, maxs_q};
				mul_b = {1'b0, maxs_q};
			end
			fas_pkg::OP_E_SQ: begin
				mul_a = {1'b0, mg_q[cmd.axis][30:0]};
				mul_b = {1'b0, mg_q[cmd.axis][30:0]};
			end
			fas_pkg::OP_CLAMP_MUL: begin
				mul_a = {17'b0, hd_q[cmd.axis]};
				mul_b = {1'b0, maxs_q};
			end
			default: ;
		endcase
	end

	// configuration and accumulators
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			gain_q   <= fas_pkg::GAIN_RST;
			radius_q <= fas_pkg::RADIUS_RST;
			for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			cnt_q    <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == fas_pkg::CFG_GAIN) gain_q <= cfg_data[30:0];
				else radius_q <= cfg_data[30:0];
			end
			if (cmd.op == fas_pkg::OP_ACCUM && hit) begin
				cnt_q <= cnt_q + 1'b1;
				for (int i = 0; i < 3; i++)
					sum_q[i] <= sum_q[i] + {{(SUM_W - 32){vel_q[i][31]}}, vel_q[i]};
			end else if (cmd.op == fas_pkg::OP_PREP) begin
				cnt_q <= '0;
				for (int i = 0; i < 3; i++) sum_q[i] <= '0;
			end
		end
	end

	// datapath registers
	always_ff @(posedge clk) begin
		mul_s1 <= mul_a * mul_b;
		case (cmd.op)
			fas_pkg::OP_LOAD: begin
				for (int i = 0; i < 3; i++) begin
					ad_q[i]  <= adiff[i][30:0];
					vel_q[i] <= other_vel[i];
				end
				far_q  <= adiff[0][31] | adiff[1][31] | adiff[2][31];
				self_q <= is_self;
				last_q <= last_neighbor;
				maxs_q <= max_speed;
			end
			fas_pkg::OP_SQUARE: begin
				for (int i = 0; i < 3; i++) sqd_s1[i] <= ad_q[i] * ad_q[i];
				r2_s1 <= radius_q * radius_q;
			end
			fas_pkg::OP_MUL_HI: plo_q <= mul_s1[PLO_W-1:0];
			fas_pkg::OP_DIV_LOAD_W: begin
				dvd_q <= p_full[PW-1:fas_pkg::FRAC_W];
				dvs_q <= 31'(cnt_q) + 31'd1;
				rem_q <= '0;
			end
			fas_pkg::OP_DIV_STEP: begin
				rem_q <= dge ? ddif[30:0] : dtry[30:0];
				dvd_q <= {dvd_q[DW-2:0], dge};
			end
			fas_pkg::OP_MG_STORE: begin
				mg_q[cmd.axis] <= dvd_q;
				sg_q[cmd.axis] <= sum_q[cmd.axis][SUM_W-1];
			end
			fas_pkg::OP_PREP: begin
				for (int i = 0; i < 3; i++) cs_q[i] <= mg_q[i];
				sqsum_q <= '0;
			end
			fas_pkg::OP_ZERO_OUT: begin
				for (int i = 0; i < 3; i++) begin
					des_q[i]  <= '0;
					head_q[i] <= '0;
				end
			end
			fas_pkg::OP_SHIFT: for (int i = 0; i < 3; i++) cs_q[i] <= cs_q[i] >> 1;
			fas_pkg::OP_CADD: sqsum_q <= sqsum_q + mul_s1[61:0];
			fas_pkg::OP_SQRT_INIT: begin
				sv_q <= sqsum_q;
				sr_q <= '0;
				sb_q <= fas_pkg::SQRT_TOP;
			end
			fas_pkg::OP_SQRT_STEP: begin
				if (sv_q >= sprobe) begin
					sv_q <= sv_q - sprobe;
					sr_q <= (sr_q >> 1) + sb_q;
				end else begin
					sr_q <= sr_q >> 1;
				end
				sb_q <= sb_q >> 2;
			end
			fas_pkg::OP_DIV_LOAD_H: begin
				dvd_q <= DW'({cs_q[cmd.axis][29:0], 14'b0}) + DW'(sr_q[30:1]);
				dvs_q <= sr_q[30:0];
				rem_q <= '0;
			end
			fas_pkg::OP_HD_STORE: hd_q[cmd.axis] <= dvd_q[fas_pkg::HD_W-1:0];
			fas_pkg::OP_E_INIT: begin
				msq_q <= mul_s1[61:0];
				e_q   <= '0;
			end
			fas_pkg::OP_E_ADD: e_q <= e_q + mul_s1;
			fas_pkg::OP_OVER: begin
				over_q <= (mg_q[0] > DW'(maxs_q)) || (mg_q[1] > DW'(maxs_q)) ||
					(mg_q[2] > DW'(maxs_q)) || (e_q > 64'(msq_q));
			end
			fas_pkg::OP_WRITE_OUT: begin
				des_q[cmd.axis]  <= sg_q[cmd.axis] ? (32'd0 - vmag) : vmag;
				head_q[cmd.axis] <= sg_q[cmd.axis] ? (16'd0 - hmag) : hmag;
			end
			default: ;
		endcase
	end

endmodule

>>> hw/rtl/flock_alignment_steering.sv
// Boids alignment steering for one agent. Neighbour entries arrive one beat at a time on nbr;
// each is tested against the squared neighbourhood radius and, when in range and not the agent
// itself, its velocity is added to the running sums (at most MAX_NEIGHBORS entries count). A
// new entry is taken only once the previous one is through. The entry flagged last_neighbor also
// launches the result computation, which runs on one shared 32x32 multiplier, a one-bit-per-cycle
// restoring divider and a two-bits-per-cycle square root; the divider makes six passes, one per
// axis for the magnitude and one per axis for the heading. One result beat is then offered on res;
// no entry is taken until it is delivered. Configuration writes are always ready and must only be
// issued while the block is idle.
module flock_alignment_steering #(
	parameter int MAX_NEIGHBORS = 256
) (
	input logic clk,
	input logic arst_n,
	fas_nbr_if.sink   nbr,
	fas_res_if.source res,
	fas_cfg_if.sink   cfg
);

	fas_pkg::cmd_t      cmd;
	fas_pkg::sts_t      sts;
	logic signed [31:0] self_pos [0:2];
	logic signed [31:0] other_pos [0:2];
	logic signed [31:0] other_vel [0:2];
	logic signed [31:0] desired [0:2];
	logic signed [15:0] heading [0:2];

	assign cfg.ready = 1'b1;

	assign self_pos[0]  = nbr.self_pos_x;
	assign self_pos[1]  = nbr.self_pos_y;
	assign self_pos[2]  = nbr.self_pos_z;
	assign other_pos[0] = nbr.other_pos_x;
	assign other_pos[1] = nbr.other_pos_y;
	assign other_pos[2] = nbr.other_pos_z;
	assign other_vel[0] = nbr.other_vel_x;
	assign other_vel[1] = nbr.other_vel_y;
	assign other_vel[2] = nbr.other_vel_z;

	assign res.desired_vel_x = desired[0];
	assign res.desired_vel_y = desired[1];
	assign res.desired_vel_z = desired[2];
	assign res.heading_x     = heading[0];
	assign res.heading_y     = heading[1];
	assign res.heading_z     = heading[2];

	fas_ctrl #(
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (nbr.valid),
		.in_ready (nbr.ready),
		.out_valid(res.valid),
		.out_ready(res.ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fas_dp #(
		.MAX_NEIGHBORS(MAX_NEIGHBORS)
	) u_dp (
		.clk          (clk),
		.arst_n       (arst_n),
		.cmd          (cmd),
		.sts          (sts),
		.cfg_we       (cfg.valid),
		.cfg_index    (cfg.index),
		.cfg_data     (cfg.data),
		.self_pos     (self_pos),
		.other_pos    (other_pos),
		.other_vel    (other_vel),
		.is_self      (nbr.is_self),
		.last_neighbor(nbr.last_neighbor),
		.max_speed    (nbr.max_speed),
		.desired      (desired),
		.heading      (heading)
	);

`ifndef SYNTHESIS
	// no entry is taken while a result is on offer
	a_no_overlap: assert property (@(posedge clk) disable iff (!arst_n)
		!(res.valid && nbr.ready))
		else $error("entry accepted while result pending");

	// block returns to accepting entries right after the result beat
	a_resume: assert property (@(posedge clk) disable iff (!arst_n)
		(res.valid && res.ready) |=> nbr.ready)
		else $error("block not idle after result beat");

	// heading stays within unit range in Q2.14
	a_heading: assert property (@(posedge clk) disable iff (!arst_n)
		res.valid |-> (res.heading_x <= 16'sd16384 && res.heading_x >= -16'sd16384 &&
		res.heading_y <= 16'sd16384 && res.heading_y >= -16'sd16384 &&
		res.heading_z <= 16'sd16384 && res.heading_z >= -16'sd16384))
		else $error("heading out of range");
`endif

endmodule
